// ===== hw/rtl/mrvme_pkg.sv =====
// Shared types, constants and helpers for the multi-reference finger match block.
// No dependencies; every other file in hw/rtl refers to this package by scoped name.
package mrvme_pkg;

	localparam int COST_W  = 32;
	localparam int CFG_W   = 20;
	localparam int FING_W  = 4;
	localparam int COUNT_W = 4;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	localparam logic [CFG_W-1:0]   SUBST_RST = 20'd10;
	localparam logic [CFG_W-1:0]   SOFT_RST  = 20'd1;
	localparam logic [CFG_W-1:0]   HARD_RST  = 20'd10000;
	localparam logic [COUNT_W-1:0] COUNT_RST = 4'd1;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_SUBST = 2'd0,
		REG_SOFT  = 2'd1,
		REG_HARD  = 2'd2,
		REG_COUNT = 2'd3
	} reg_idx_t;

	// Control that every lane sees for the current request
	typedef struct packed {
		logic               started;
		logic [COUNT_W-1:0] n_lanes;
		logic [CFG_W-1:0]   soft_sw;
		logic [CFG_W-1:0]   hard;
	} lane_ctl_t;

	// Unsigned add that clamps at all ones
	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? '1 : s[COST_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/mrvme_lane.sv =====
// One lane of the min-plus update: best predecessor cost and finger mismatch for lane LANE.
// Depends on mrvme_pkg (lane_ctl_t, sat_add, widths).
module mrvme_lane #(
	parameter int GT_MAX = 8,
	parameter int LANE   = 0
) (
	input  logic [mrvme_pkg::COST_W-1:0] pre_cost [GT_MAX],
	input  logic [mrvme_pkg::FING_W-1:0] prev_finger [GT_MAX],
	input  logic [mrvme_pkg::FING_W-1:0] est,
	input  logic [mrvme_pkg::FING_W-1:0] finger,
	input  mrvme_pkg::lane_ctl_t         ctl,
	output logic [mrvme_pkg::COST_W-1:0] best,
	output logic                         mismatch
);

	// Stay on the lane or switch in from another lane in use; a fresh hand starts at zero
	always_comb begin
		logic [mrvme_pkg::CFG_W-1:0]  sw;
		logic [mrvme_pkg::COST_W-1:0] cand;
		best = pre_cost[LANE];
		for (int zp = 0; zp < GT_MAX; zp++) begin
			sw   = (prev_finger[zp] == prev_finger[LANE]) ? ctl.soft_sw : ctl.hard;
			cand = mrvme_pkg::sat_add(pre_cost[zp],
				{{(mrvme_pkg::COST_W-mrvme_pkg::CFG_W){1'b0}}, sw});
			if (zp != LANE && mrvme_pkg::COUNT_W'(zp) < ctl.n_lanes && cand < best) begin
				best = cand;
			end
		end
		if (!ctl.started) begin
			best = '0;
		end
	end

	// Compare as raw 4-bit patterns
	assign mismatch = (finger != est);

endmodule

// ===== hw/rtl/mrvme_merge.sv =====
// Merging stage: minimum lane cost per hand, saturating sum, and the result register.
// Depends on mrvme_pkg (sat_add, widths).
module mrvme_merge #(
	parameter int GT_MAX = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mrvme_pkg::COST_W-1:0]  cost [2][GT_MAX],
	input  logic [1:0]                    started,
	input  logic [mrvme_pkg::COUNT_W-1:0] n_lanes,
	input  logic                          take,
	output logic                          ready,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [mrvme_pkg::COST_W-1:0]  total_error
);

	logic                         valid_q;
	logic [mrvme_pkg::COST_W-1:0] total_q;
	logic [mrvme_pkg::COST_W-1:0] hand_min [2];
	logic [mrvme_pkg::COST_W-1:0] total;

	// Find each hand's cheapest lane among those in use
	always_comb begin
		for (int h = 0; h < 2; h++) begin
			hand_min[h] = cost[h][0];
			for (int z = 1; z < GT_MAX; z++) begin
				if (mrvme_pkg::COUNT_W'(z) < n_lanes && cost[h][z] < hand_min[h]) begin
					hand_min[h] = cost[h][z];
				end
			end
		end
		total = mrvme_pkg::sat_add(started[0] ? hand_min[0] : '0,
			started[1] ? hand_min[1] : '0);
	end

	// Load the result when the slot is empty or being drained
	assign ready = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && take) begin
			total_q <= total;
		end
	end

	assign res_valid   = valid_q;
	assign total_error = total_q;

endmodule

// ===== hw/rtl/multi_reference_viterbi_match_error.sv =====
// Top level: config registers, per-hand lane state, GT_MAX lanes and the merging stage.
// Depends on mrvme_pkg, mrvme_lane and mrvme_merge.
//
//  channel   | signals                                    | direction
//  ----------+--------------------------------------------+----------
//  request   | req_valid, req_stall, est_finger,          | in
//            | gt_fingers, first_note                     |
//  result    | res_valid, res_stall, total_error          | out
//  config    | psel, penable, pwrite, paddr, pwdata,      | in/out
//            | prdata, pready                             |
//
// For a request, the lanes work in the accept cycle and their results are registered; the lane
// state is written back once the merge can take it, and the next request waits for that write-back.
// After the write-back, the merge request flag loads the result into the result register, where it waits.
// Reset clears all lane costs, previous fingers and hand flags and loads config defaults.
// A stalled result backs up into the write-back stage and then into req_stall.
module multi_reference_viterbi_match_error #(
	parameter int GT_MAX = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mrvme_pkg::ADDR_W-1:0]  paddr,
	input  logic [mrvme_pkg::DATA_W-1:0]  pwdata,
	output logic [mrvme_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic signed [mrvme_pkg::FING_W-1:0] est_finger,
	input  logic [31:0]                   gt_fingers,
	input  logic                          first_note,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [mrvme_pkg::COST_W-1:0]  total_error
);

	localparam int CW = mrvme_pkg::COST_W;
	localparam int FW = mrvme_pkg::FING_W;

	// Configuration registers
	logic [mrvme_pkg::CFG_W-1:0]   subst_q, soft_q, hard_q;
	logic [mrvme_pkg::COUNT_W-1:0] count_q;
	logic [mrvme_pkg::COUNT_W-1:0] n_lanes;
	mrvme_pkg::reg_idx_t           reg_idx;

	// Per-hand state
	logic [CW-1:0] cost_q [2][GT_MAX];
	logic [FW-1:0] prev_q [2][GT_MAX];
	logic [1:0]    started_q;

	// Lane stage outputs and write-back stage
	logic [CW-1:0] best [GT_MAX];
	logic [GT_MAX-1:0] mis;
	logic [FW-1:0] finger [GT_MAX];
	mrvme_pkg::lane_ctl_t ctl;
	logic          hand;
	logic          accept;

	logic          valid_s1;
	logic [CW-1:0] best_s1 [GT_MAX];
	logic [GT_MAX-1:0] mis_s1;
	logic [FW-1:0] finger_s1 [GT_MAX];
	logic          hand_s1;
	logic          first_s1;
	logic          s1_go;

	logic          valid_s2;
	logic          merge_ready;

	// Config port: one wait-free access, index from the word address
	assign pready  = 1'b1;
	assign reg_idx = mrvme_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subst_q <= mrvme_pkg::SUBST_RST;
			soft_q  <= mrvme_pkg::SOFT_RST;
			hard_q  <= mrvme_pkg::HARD_RST;
			count_q <= mrvme_pkg::COUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				mrvme_pkg::REG_SUBST: subst_q <= pwdata[mrvme_pkg::CFG_W-1:0];
				mrvme_pkg::REG_SOFT:  soft_q  <= pwdata[mrvme_pkg::CFG_W-1:0];
				mrvme_pkg::REG_HARD:  hard_q  <= pwdata[mrvme_pkg::CFG_W-1:0];
				mrvme_pkg::REG_COUNT: count_q <= pwdata[mrvme_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mrvme_pkg::REG_SUBST: prdata = {{(mrvme_pkg::DATA_W-mrvme_pkg::CFG_W){1'b0}}, subst_q};
			mrvme_pkg::REG_SOFT:  prdata = {{(mrvme_pkg::DATA_W-mrvme_pkg::CFG_W){1'b0}}, soft_q};
			mrvme_pkg::REG_HARD:  prdata = {{(mrvme_pkg::DATA_W-mrvme_pkg::CFG_W){1'b0}}, hard_q};
			mrvme_pkg::REG_COUNT: prdata = {{(mrvme_pkg::DATA_W-mrvme_pkg::COUNT_W){1'b0}}, count_q};
			default:              prdata = '0;
		endcase
	end

	// Clamp the lane count to 1..GT_MAX
	always_comb begin
		if (count_q == '0) begin
			n_lanes = mrvme_pkg::COUNT_W'(1);
		end else if (count_q > mrvme_pkg::COUNT_W'(GT_MAX)) begin
			n_lanes = mrvme_pkg::COUNT_W'(GT_MAX);
		end else begin
			n_lanes = count_q;
		end
	end

	// Handshake: hold off while a write-back is pending or the merge is blocked
	assign s1_go     = valid_s1 && (!valid_s2 || merge_ready);
	assign req_stall = valid_s1 || (valid_s2 && !merge_ready);
	assign accept    = req_valid && !req_stall;

	// Lane control for the hand this request belongs to
	assign hand        = est_finger[FW-1];
	assign ctl.started = started_q[hand] && !first_note;
	assign ctl.n_lanes = n_lanes;
	assign ctl.soft_sw = soft_q;
	assign ctl.hard    = hard_q;

	// Lanes work side by side on the selected hand's costs
	for (genvar z = 0; z < GT_MAX; z++) begin : g_lane
		assign finger[z] = gt_fingers[FW*z +: FW];

		mrvme_lane #(
			.GT_MAX(GT_MAX),
			.LANE  (z)
		) u_lane (
			.pre_cost   (cost_q[hand]),
			.prev_finger(prev_q[hand]),
			.est        (est_finger),
			.finger     (finger[z]),
			.ctl        (ctl),
			.best       (best[z]),
			.mismatch   (mis[z])
		);
	end

	// Capture lane results on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			best_s1   <= best;
			mis_s1    <= mis;
			finger_s1 <= finger;
			hand_s1   <= hand;
			first_s1  <= first_note;
		end
	end

	// Write back: optional clear, then new costs for lanes in use and all fingers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < 2; h++) begin
				for (int z = 0; z < GT_MAX; z++) begin
					cost_q[h][z] <= '0;
					prev_q[h][z] <= '0;
				end
			end
			started_q <= '0;
		end else if (s1_go) begin
			for (int h = 0; h < 2; h++) begin
				for (int z = 0; z < GT_MAX; z++) begin
					if (1'(h) == hand_s1) begin
						if (mrvme_pkg::COUNT_W'(z) < n_lanes) begin
							cost_q[h][z] <= mis_s1[z]
								? mrvme_pkg::sat_add(best_s1[z],
									{{(CW-mrvme_pkg::CFG_W){1'b0}}, subst_q})
								: best_s1[z];
						end else if (first_s1) begin
							cost_q[h][z] <= '0;
						end
						prev_q[h][z] <= finger_s1[z];
					end else if (first_s1) begin
						cost_q[h][z] <= '0;
						prev_q[h][z] <= '0;
					end
				end
			end
			started_q <= (first_s1 ? 2'b00 : started_q) | (2'b01 << hand_s1);
		end
	end

	// Merge request pending after write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= s1_go || (valid_s2 && !merge_ready);
		end
	end

	mrvme_merge #(
		.GT_MAX(GT_MAX)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.cost       (cost_q),
		.started    (started_q),
		.n_lanes    (n_lanes),
		.take       (valid_s2),
		.ready      (merge_ready),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.total_error(total_error)
	);

endmodule
